>>> hw/rtl/sdh_pkg.sv
// Package for the SD card SPI-mode host sequencer.
// Phase codes, card type and status codes, register indexes and field types.
// No dependencies.
package sdh_pkg;

  localparam int BLOCK_BYTES = 512;

  typedef enum logic [23:0] {
    P_IDLE   = 24'h000001,
    P_CMD0   = 24'h000002,
    P_CMD8   = 24'h000004,
    P_V2LOOP = 24'h000008,
    P_CMD58  = 24'h000010,
    P_PROBE  = 24'h000020,
    P_V1LOOP = 24'h000040,
    P_CMD16  = 24'h000080,
    P_CMD17  = 24'h000100,
    P_CMD24  = 24'h000200,
    P_WAKE   = 24'h000400,
    P_GAP0   = 24'h000800,
    P_OCR8   = 24'h001000,
    P_OCR58  = 24'h002000,
    P_RDGAP  = 24'h004000,
    P_RDTOK  = 24'h008000,
    P_RDDATA = 24'h010000,
    P_RDCRC  = 24'h020000,
    P_WRGAP  = 24'h040000,
    P_WRTOK  = 24'h080000,
    P_WRDATA = 24'h100000,
    P_WRCRC  = 24'h200000,
    P_WRRESP = 24'h400000,
    P_WRBUSY = 24'h800000
  } phase_t;

  localparam logic [1:0] K_INIT  = 2'd0;
  localparam logic [1:0] K_READ  = 2'd1;
  localparam logic [1:0] K_WRITE = 2'd2;
  localparam logic [1:0] K_XCHG  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RD_FAIL  = 2'd1;
  localparam logic [1:0] ST_WR_FAIL  = 2'd2;
  localparam logic [1:0] ST_INI_FAIL = 2'd3;

  localparam logic [2:0] CT_UNKNOWN = 3'd0;
  localparam logic [2:0] CT_MMC     = 3'd1;
  localparam logic [2:0] CT_SDV1    = 3'd2;
  localparam logic [2:0] CT_SDV2_BY = 3'd3;
  localparam logic [2:0] CT_SDV2_BL = 3'd4;

  localparam logic [2:0] R_RESP_TRIES = 3'd0;
  localparam logic [2:0] R_TOK_TMO    = 3'd1;
  localparam logic [2:0] R_TRIES_V2   = 3'd2;
  localparam logic [2:0] R_TRIES_V1   = 3'd3;
  localparam logic [2:0] R_WAKE       = 3'd4;

  localparam logic [7:0] C_CMD0   = 8'h40;
  localparam logic [7:0] C_CMD1   = 8'h41;
  localparam logic [7:0] C_CMD8   = 8'h48;
  localparam logic [7:0] C_CMD16  = 8'h50;
  localparam logic [7:0] C_CMD17  = 8'h51;
  localparam logic [7:0] C_CMD24  = 8'h58;
  localparam logic [7:0] C_CMD55  = 8'h77;
  localparam logic [7:0] C_CMD58  = 8'h7A;
  localparam logic [7:0] C_ACMD41 = 8'hE9;

  typedef struct packed {
    logic [7:0]  response_tries;
    logic [15:0] token_timeout;
    logic [14:0] init_tries_v2;
    logic [14:0] init_tries_v1;
    logic [7:0]  wake_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] block_address;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] mosi_byte;
    logic       chip_select;
    logic       slow_clock;
    logic       wants_write_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] card_type;
  } res_t;

endpackage

>>> hw/rtl/sd_spi_host_sequencer.sv
// Top level of the SD card SPI-mode host sequencer: stream ports, output register.
// Depends on sdh_pkg, sdh_cfg_regs and sdh_core.
//
// Each input word is a request (init, read, write) or the result of one SPI
// byte exchange; each gives exactly one result word naming the next byte, chip
// select and bus speed, or the end of the request. One word is taken per
// cycle: the next-step logic sits between the input and a one-deep output
// register, so the rate is one word per clock when the output side keeps up.
// The result shows in the cycle after its word. Configure only while idle.
module sd_spi_host_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // block_address[31:0], miso_byte[39:32], write_byte[47:40]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // send_valid, mosi_byte, chip_select, slow_clock,
                                  // wants_write_byte, data_valid, data_byte, done_res,
                                  // status, card_type (bits 0..26)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sdh_pkg::cfg_t  cfg;
  sdh_pkg::item_t item;
  sdh_pkg::res_t  res;
  sdh_pkg::res_t  res_r;
  logic           vld_r;
  logic           step;

  assign cfg_ready = 1'b1;

  sdh_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .wr_en(cfg_valid), .wr_index(cfg_index),
    .wr_data(cfg_data), .cfg(cfg)
  );

  assign item.kind          = in_tuser;
  assign item.block_address = in_tdata[31:0];
  assign item.miso_byte     = in_tdata[39:32];
  assign item.write_byte    = in_tdata[47:40];

  // Accept whenever the output register is free or draining
  assign in_tready = !vld_r || out_tready;
  assign step      = in_tvalid && in_tready;

  sdh_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(item), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_tready) vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {5'd0, res_r.card_type, res_r.status, res_r.done_res,
                       res_r.data_byte, res_r.data_valid, res_r.wants_write_byte,
                       res_r.slow_clock, res_r.chip_select, res_r.mosi_byte,
                       res_r.send_valid};

endmodule

>>> hw/rtl/sdh_cfg_regs.sv
// Configuration register file of the SD host sequencer.
// Depends on sdh_pkg.
module sdh_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [31:0]       wr_data,
  output sdh_pkg::cfg_t     cfg
);

  sdh_pkg::cfg_t cfg_r;

  // Write the addressed register; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_tries <= 8'd10;
      cfg_r.token_timeout  <= 16'd65535;
      cfg_r.init_tries_v2  <= 15'd12000;
      cfg_r.init_tries_v1  <= 15'd25000;
      cfg_r.wake_bytes     <= 8'd10;
    end else if (wr_en) begin
      case (wr_index)
        sdh_pkg::R_RESP_TRIES: cfg_r.response_tries <= wr_data[7:0];
        sdh_pkg::R_TOK_TMO:    cfg_r.token_timeout  <= wr_data[15:0];
        sdh_pkg::R_TRIES_V2:   cfg_r.init_tries_v2  <= wr_data[14:0];
        sdh_pkg::R_TRIES_V1:   cfg_r.init_tries_v1  <= wr_data[14:0];
        sdh_pkg::R_WAKE:       cfg_r.wake_bytes     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/sdh_core.sv
// Sequencer state and next-step logic of the SD host: one item per cycle while step is high.
// Depends on sdh_pkg.
module sdh_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  sdh_pkg::item_t    item,
  input  sdh_pkg::cfg_t     cfg,
  output sdh_pkg::res_t     res
);

  sdh_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic        app_r, app_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [14:0] try_r, try_nxt;
  logic [2:0]  type_r, type_nxt;
  logic [7:0]  regb_r [4];
  logic        regb_we;
  logic [7:0]  regb0_v, regb2_v;

  // Command frame byte for a given position, code, app flag and argument
  function automatic logic [7:0] frame_byte(input logic [15:0] p, input logic [7:0] cc,
                                            input logic ap, input logic [31:0] ar);
    logic [7:0]  code;
    logic [31:0] a;
    logic [7:0]  b;
    code = ap ? sdh_pkg::C_CMD55 : {1'b0, cc[6:0]};
    a    = ap ? 32'd0 : ar;
    b    = 8'hFF;
    case (p)
      16'd2: b = code;
      16'd3: b = a[31:24];
      16'd4: b = a[23:16];
      16'd5: b = a[15:8];
      16'd6: b = a[7:0];
      16'd7: b = (code == sdh_pkg::C_CMD0) ? 8'h95 :
                 (code == sdh_pkg::C_CMD8) ? 8'h87 : 8'h01;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

  always_comb begin
    logic [7:0]  miso;
    logic [7:0]  tries;
    logic [15:0] c1;
    logic        have_resp;
    logic [7:0]  r;
    logic        start;
    logic [7:0]  s_code;
    logic [31:0] s_arg;
    logic        fin;
    logic [1:0]  st;
    logic [14:0] tdec;

    miso      = item.miso_byte;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    arg_nxt   = arg_r;
    app_nxt   = app_r;
    cnt_nxt   = cnt_r;
    try_nxt   = try_r;
    type_nxt  = type_r;
    regb_we   = 1'b0;
    res       = '0;
    have_resp = 1'b0;
    r         = miso;
    start     = 1'b0;
    s_code    = 8'd0;
    s_arg     = 32'd0;
    fin       = 1'b0;
    st        = sdh_pkg::ST_OK;
    tries     = (cfg.response_tries == 8'd0) ? 8'd1 : cfg.response_tries;
    c1        = cnt_r + 16'd1;
    tdec      = try_r - 15'd1;

    case (item.kind)
      sdh_pkg::K_INIT: begin
        type_nxt = sdh_pkg::CT_UNKNOWN;
        if (cfg.wake_bytes != 8'd0) begin
          phase_nxt = sdh_pkg::P_WAKE;
          cnt_nxt = 16'd0;
          res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.slow_clock = 1'b1;
        end else begin
          start = 1'b1; phase_nxt = sdh_pkg::P_CMD0; s_code = sdh_pkg::C_CMD0;
        end
      end
      sdh_pkg::K_READ: begin
        start = 1'b1; phase_nxt = sdh_pkg::P_CMD17;
        s_code = sdh_pkg::C_CMD17; s_arg = item.block_address;
      end
      sdh_pkg::K_WRITE: begin
        start = 1'b1; phase_nxt = sdh_pkg::P_CMD24;
        s_code = sdh_pkg::C_CMD24; s_arg = item.block_address;
      end
      default: begin
        case (phase_r)
          sdh_pkg::P_CMD0, sdh_pkg::P_CMD8, sdh_pkg::P_V2LOOP, sdh_pkg::P_CMD58,
          sdh_pkg::P_PROBE, sdh_pkg::P_V1LOOP, sdh_pkg::P_CMD16, sdh_pkg::P_CMD17,
          sdh_pkg::P_CMD24: begin
            // Advance the command frame or poll for its response
            if (cnt_r >= 16'd8 && !(miso[7] && ((cnt_r - 16'd7) < {8'd0, tries}))) begin
              if (app_r && miso <= 8'd1) begin
                app_nxt = 1'b0; cnt_nxt = 16'd0;
                res.send_valid = 1'b1;
                res.mosi_byte = frame_byte(16'd0, code_r, 1'b0, arg_r);
              end else begin
                have_resp = 1'b1;
              end
            end else begin
              cnt_nxt = c1;
              res.send_valid = 1'b1; res.chip_select = 1'b1;
              res.mosi_byte = frame_byte(c1, code_r, app_r, arg_r);
            end
          end
          sdh_pkg::P_WAKE: begin
            cnt_nxt = c1;
            if (c1 < {8'd0, cfg.wake_bytes}) begin
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.slow_clock = 1'b1;
            end else begin
              start = 1'b1; phase_nxt = sdh_pkg::P_CMD0; s_code = sdh_pkg::C_CMD0;
            end
          end
          sdh_pkg::P_GAP0: begin
            start = 1'b1; phase_nxt = sdh_pkg::P_CMD8;
            s_code = sdh_pkg::C_CMD8; s_arg = 32'h1AA;
          end
          sdh_pkg::P_OCR8, sdh_pkg::P_OCR58: begin
            regb_we = 1'b1;
            cnt_nxt = c1;
            if (c1 < 16'd4) begin
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
            end else if (phase_r == sdh_pkg::P_OCR58) begin
              type_nxt = regb0_v[6] ? sdh_pkg::CT_SDV2_BL : sdh_pkg::CT_SDV2_BY;
              fin = 1'b1;
            end else if (regb2_v == 8'h01 && miso == 8'hAA) begin
              try_nxt = cfg.init_tries_v2;
              if (cfg.init_tries_v2 == 15'd0) fin = 1'b1;
              else begin
                start = 1'b1; phase_nxt = sdh_pkg::P_V2LOOP;
                s_code = sdh_pkg::C_ACMD41; s_arg = 32'h4000_0000;
              end
            end else fin = 1'b1;
          end
          sdh_pkg::P_RDGAP: begin
            phase_nxt = sdh_pkg::P_RDTOK; cnt_nxt = 16'd0;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end
          sdh_pkg::P_RDTOK, sdh_pkg::P_WRBUSY: begin
            // Poll for start token or busy end within the timeout
            if (miso == ((phase_r == sdh_pkg::P_RDTOK) ? 8'hFE : 8'hFF) &&
                c1 < cfg.token_timeout && cnt_r != 16'hFFFF) begin
              if (phase_r == sdh_pkg::P_RDTOK) begin
                phase_nxt = sdh_pkg::P_RDDATA; cnt_nxt = 16'd0;
                res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
              end else fin = 1'b1;
            end else if (cnt_r == 16'hFFFF || c1 >= cfg.token_timeout) begin
              fin = 1'b1;
              st = (phase_r == sdh_pkg::P_RDTOK) ? sdh_pkg::ST_RD_FAIL : sdh_pkg::ST_WR_FAIL;
            end else begin
              cnt_nxt = c1;
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
            end
          end
          sdh_pkg::P_RDDATA: begin
            res.data_valid = 1'b1; res.data_byte = miso;
            cnt_nxt = c1;
            if (c1 >= 16'(sdh_pkg::BLOCK_BYTES)) begin
              phase_nxt = sdh_pkg::P_RDCRC; cnt_nxt = 16'd0;
            end
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end
          sdh_pkg::P_RDCRC, sdh_pkg::P_WRCRC: begin
            cnt_nxt = c1;
            if (c1 < 16'd2) begin
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
            end else if (phase_r == sdh_pkg::P_RDCRC) fin = 1'b1;
            else begin
              phase_nxt = sdh_pkg::P_WRRESP;
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
            end
          end
          sdh_pkg::P_WRGAP: begin
            phase_nxt = sdh_pkg::P_WRTOK;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFE; res.chip_select = 1'b1;
            res.wants_write_byte = 1'b1;
          end
          sdh_pkg::P_WRTOK: begin
            phase_nxt = sdh_pkg::P_WRDATA; cnt_nxt = 16'd0;
            res.send_valid = 1'b1; res.mosi_byte = item.write_byte;
            res.chip_select = 1'b1; res.wants_write_byte = (sdh_pkg::BLOCK_BYTES > 1);
          end
          sdh_pkg::P_WRDATA: begin
            res.send_valid = 1'b1; res.chip_select = 1'b1;
            if ({1'b0, c1} < 17'(sdh_pkg::BLOCK_BYTES)) begin
              cnt_nxt = c1;
              res.mosi_byte = item.write_byte;
              res.wants_write_byte = ({1'b0, c1} + 17'd1) < 17'(sdh_pkg::BLOCK_BYTES);
            end else begin
              phase_nxt = sdh_pkg::P_WRCRC; cnt_nxt = 16'd0; res.mosi_byte = 8'hFF;
            end
          end
          sdh_pkg::P_WRRESP: begin
            if (miso[4:0] != 5'h05) begin
              fin = 1'b1; st = sdh_pkg::ST_WR_FAIL;
            end else begin
              phase_nxt = sdh_pkg::P_WRBUSY; cnt_nxt = 16'd0;
              res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
            end
          end
          default: phase_nxt = sdh_pkg::P_IDLE;
        endcase
      end
    endcase

    // React to a finished command response
    if (have_resp) begin
      case (phase_r)
        sdh_pkg::P_CMD0:
          if (r == 8'd1) begin
            phase_nxt = sdh_pkg::P_GAP0;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end else begin
            fin = 1'b1; st = sdh_pkg::ST_INI_FAIL;
          end
        sdh_pkg::P_CMD8:
          if (r == 8'd1) begin
            phase_nxt = sdh_pkg::P_OCR8; cnt_nxt = 16'd0;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end else begin
            start = 1'b1; phase_nxt = sdh_pkg::P_PROBE; s_code = sdh_pkg::C_ACMD41;
          end
        sdh_pkg::P_V2LOOP:
          if (r == 8'd0) begin
            start = 1'b1; phase_nxt = sdh_pkg::P_CMD58; s_code = sdh_pkg::C_CMD58;
          end else begin
            try_nxt = tdec;
            if (tdec == 15'd0) fin = 1'b1;
            else begin start = 1'b1; s_code = code_r; s_arg = arg_r; end
          end
        sdh_pkg::P_CMD58:
          if (r == 8'd0) begin
            phase_nxt = sdh_pkg::P_OCR58; cnt_nxt = 16'd0;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end else fin = 1'b1;
        sdh_pkg::P_PROBE: begin
          try_nxt = cfg.init_tries_v1;
          if (cfg.init_tries_v1 == 15'd0) begin
            type_nxt = sdh_pkg::CT_UNKNOWN; fin = 1'b1;
          end else begin
            type_nxt = (r <= 8'd1) ? sdh_pkg::CT_SDV1 : sdh_pkg::CT_MMC;
            start = 1'b1; phase_nxt = sdh_pkg::P_V1LOOP;
            s_code = (r <= 8'd1) ? sdh_pkg::C_ACMD41 : sdh_pkg::C_CMD1;
          end
        end
        sdh_pkg::P_V1LOOP:
          if (r == 8'd0) begin
            start = 1'b1; phase_nxt = sdh_pkg::P_CMD16;
            s_code = sdh_pkg::C_CMD16; s_arg = 32'(sdh_pkg::BLOCK_BYTES);
          end else begin
            try_nxt = tdec;
            if (tdec == 15'd0) begin type_nxt = sdh_pkg::CT_UNKNOWN; fin = 1'b1; end
            else begin start = 1'b1; s_code = code_r; s_arg = arg_r; end
          end
        sdh_pkg::P_CMD16: begin
          if (r != 8'd0) type_nxt = sdh_pkg::CT_UNKNOWN;
          fin = 1'b1;
        end
        sdh_pkg::P_CMD17:
          if (r != 8'd0) begin fin = 1'b1; st = sdh_pkg::ST_RD_FAIL; end
          else begin
            phase_nxt = sdh_pkg::P_RDGAP;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end
        default:
          if (r != 8'd0) begin fin = 1'b1; st = sdh_pkg::ST_WR_FAIL; end
          else begin
            phase_nxt = sdh_pkg::P_WRGAP;
            res.send_valid = 1'b1; res.mosi_byte = 8'hFF; res.chip_select = 1'b1;
          end
      endcase
    end

    // Open a new command frame: first byte is deselected 0xFF
    if (start) begin
      code_nxt = s_code; arg_nxt = s_arg; app_nxt = s_code[7]; cnt_nxt = 16'd0;
      res = '0;
      res.send_valid = 1'b1; res.mosi_byte = 8'hFF;
    end
    if (fin) begin
      phase_nxt = sdh_pkg::P_IDLE;
      res.done_res = 1'b1; res.status = st;
    end
    res.card_type = type_nxt;
  end

  // Register bytes of the OCR and R7 replies; the current byte bypasses
  assign regb0_v = regb_r[0];
  assign regb2_v = regb_r[2];

  always_ff @(posedge clk) begin
    if (step && regb_we) regb_r[cnt_r[1:0]] <= item.miso_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdh_pkg::P_IDLE;
      code_r  <= '0;
      arg_r   <= '0;
      app_r   <= 1'b0;
      cnt_r   <= '0;
      try_r   <= '0;
      type_r  <= sdh_pkg::CT_UNKNOWN;
    end else if (step) begin
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      arg_r   <= arg_nxt;
      app_r   <= app_nxt;
      cnt_r   <= cnt_nxt;
      try_r   <= try_nxt;
      type_r  <= type_nxt;
    end
  end

  // A finished request always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> (phase_r == sdh_pkg::P_IDLE))
    else $error("done without idle");
  // A result never both sends and finishes
  a_send_done: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(res.send_valid && res.done_res))
    else $error("send and done together");
  // Read data only flows in the data phase
  a_data_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.data_valid) |-> (phase_r == sdh_pkg::P_RDDATA))
    else $error("data outside read phase");

endmodule

>>> bench/sdh_checker.sv
// Checker for the SD card SPI-mode host sequencer: watches the input, result and
// register-write channels, predicts each result word and compares it.
// Depends on sdh_pkg.
module sdh_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          results_seen,
  output int          requests_done
);

  // register copies
  logic [7:0]  resp_tries;
  logic [15:0] tok_limit;
  logic [14:0] tries_v2;
  logic [14:0] tries_v1;
  logic [7:0]  wake_cnt;

  // sequencer state copy
  sdh_pkg::phase_t phase;
  logic [7:0]  cmd_code;
  logic [31:0] cmd_arg;
  logic        app_pend;
  logic [15:0] bcnt;
  logic [14:0] tries_left;
  logic [7:0]  ocr [4];
  logic [2:0]  ctype;

  sdh_pkg::res_t nxt;
  sdh_pkg::res_t expected_words [$];

  function automatic void emit(logic [7:0] b, logic cs, logic slow, logic wants);
    nxt.send_valid       = 1'b1;
    nxt.mosi_byte        = b;
    nxt.chip_select      = cs;
    nxt.slow_clock       = slow;
    nxt.wants_write_byte = wants;
  endfunction

  function automatic void end_request(logic [1:0] st);
    nxt.done_res = 1'b1;
    nxt.status   = st;
    phase        = sdh_pkg::P_IDLE;
  endfunction

  // Next byte of the six-byte command frame, framed by a leading idle byte pair.
  function automatic void frame_byte();
    logic [7:0]  code;
    logic [31:0] arg;
    logic [7:0]  b;
    int          p;
    p    = int'(bcnt);
    code = app_pend ? sdh_pkg::C_CMD55 : {1'b0, cmd_code[6:0]};
    arg  = app_pend ? 32'd0 : cmd_arg;
    b    = 8'hFF;
    if (p == 2) b = code;
    else if (p >= 3 && p <= 6) b = 8'(arg >> (8 * (6 - p)));
    else if (p == 7) b = (code == sdh_pkg::C_CMD0) ? 8'h95 :
                         (code == sdh_pkg::C_CMD8) ? 8'h87 : 8'h01;
    emit(b, p != 0, 1'b0, 1'b0);
  endfunction

  function automatic void cmd_begin(sdh_pkg::phase_t ph, logic [7:0] code,
                                    logic [31:0] arg);
    phase    = ph;
    cmd_code = code;
    cmd_arg  = arg;
    app_pend = code[7];
    bcnt     = '0;
    frame_byte();
  endfunction

  // Returns the response byte once the command is complete, else -1.
  function automatic int cmd_step(logic [7:0] m);
    int p;
    int tries;
    p = int'(bcnt);
    if (p >= 8) begin
      tries = (resp_tries != 8'd0) ? int'(resp_tries) : 1;
      if (!(m[7] && (p - 7) < tries)) begin
        if (app_pend) begin
          if (m > 8'd1) return int'(m);
          app_pend = 1'b0;
          bcnt     = '0;
          frame_byte();
          return -1;
        end
        return int'(m);
      end
    end
    bcnt = bcnt + 16'd1;
    frame_byte();
    return -1;
  endfunction

  function automatic bit retry_cmd();
    tries_left = tries_left - 15'd1;
    if (tries_left == 15'd0) return 1'b0;
    cmd_begin(phase, cmd_code, cmd_arg);
    return 1'b1;
  endfunction

  // 1 target seen, -1 budget spent, 0 keep polling.
  function automatic int poll_for(logic [7:0] m, logic [7:0] target);
    int c;
    c = int'(bcnt) + 1;
    if (m == target && c < int'(tok_limit)) return 1;
    if (c >= int'(tok_limit)) return -1;
    bcnt = 16'(c);
    emit(8'hFF, 1'b1, 1'b0, 1'b0);
    return 0;
  endfunction

  function automatic void on_response(logic [7:0] r);
    logic [7:0] code;
    case (phase)
      sdh_pkg::P_CMD0: begin
        if (r == 8'd1) begin
          phase = sdh_pkg::P_GAP0;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end else end_request(sdh_pkg::ST_INI_FAIL);
      end
      sdh_pkg::P_CMD8: begin
        if (r == 8'd1) begin
          phase = sdh_pkg::P_OCR8;
          bcnt  = '0;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end else cmd_begin(sdh_pkg::P_PROBE, sdh_pkg::C_ACMD41, 32'd0);
      end
      sdh_pkg::P_V2LOOP: begin
        if (r == 8'd0) cmd_begin(sdh_pkg::P_CMD58, sdh_pkg::C_CMD58, 32'd0);
        else if (!retry_cmd()) end_request(sdh_pkg::ST_OK);
      end
      sdh_pkg::P_CMD58: begin
        if (r == 8'd0) begin
          phase = sdh_pkg::P_OCR58;
          bcnt  = '0;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end else end_request(sdh_pkg::ST_OK);
      end
      sdh_pkg::P_PROBE: begin
        if (r <= 8'd1) begin
          ctype = sdh_pkg::CT_SDV1;
          code  = sdh_pkg::C_ACMD41;
        end else begin
          ctype = sdh_pkg::CT_MMC;
          code  = sdh_pkg::C_CMD1;
        end
        tries_left = tries_v1;
        if (tries_left == 15'd0) begin
          ctype = sdh_pkg::CT_UNKNOWN;
          end_request(sdh_pkg::ST_OK);
        end else cmd_begin(sdh_pkg::P_V1LOOP, code, 32'd0);
      end
      sdh_pkg::P_V1LOOP: begin
        if (r == 8'd0) cmd_begin(sdh_pkg::P_CMD16, sdh_pkg::C_CMD16,
                                 32'(sdh_pkg::BLOCK_BYTES));
        else if (!retry_cmd()) begin
          ctype = sdh_pkg::CT_UNKNOWN;
          end_request(sdh_pkg::ST_OK);
        end
      end
      sdh_pkg::P_CMD16: begin
        if (r != 8'd0) ctype = sdh_pkg::CT_UNKNOWN;
        end_request(sdh_pkg::ST_OK);
      end
      sdh_pkg::P_CMD17: begin
        if (r != 8'd0) end_request(sdh_pkg::ST_RD_FAIL);
        else begin
          phase = sdh_pkg::P_RDGAP;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end
      end
      default: begin
        if (r != 8'd0) end_request(sdh_pkg::ST_WR_FAIL);
        else begin
          phase = sdh_pkg::P_WRGAP;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic bit in_command();
    case (phase)
      sdh_pkg::P_CMD0, sdh_pkg::P_CMD8, sdh_pkg::P_V2LOOP, sdh_pkg::P_CMD58,
      sdh_pkg::P_PROBE, sdh_pkg::P_V1LOOP, sdh_pkg::P_CMD16, sdh_pkg::P_CMD17,
      sdh_pkg::P_CMD24:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the sequencer copy by one word and return the result it gives.
  function automatic sdh_pkg::res_t next_step(logic [1:0] k, logic [31:0] a,
                                              logic [7:0] m, logic [7:0] wb);
    int r;
    int got;
    nxt = '0;
    if (k == sdh_pkg::K_INIT) begin
      ctype = sdh_pkg::CT_UNKNOWN;
      if (wake_cnt != 8'd0) begin
        phase = sdh_pkg::P_WAKE;
        bcnt  = '0;
        emit(8'hFF, 1'b0, 1'b1, 1'b0);
      end else cmd_begin(sdh_pkg::P_CMD0, sdh_pkg::C_CMD0, 32'd0);
    end else if (k == sdh_pkg::K_READ) begin
      cmd_begin(sdh_pkg::P_CMD17, sdh_pkg::C_CMD17, a);
    end else if (k == sdh_pkg::K_WRITE) begin
      cmd_begin(sdh_pkg::P_CMD24, sdh_pkg::C_CMD24, a);
    end else if (in_command()) begin
      r = cmd_step(m);
      if (r >= 0) on_response(r[7:0]);
    end else begin
      case (phase)
        sdh_pkg::P_WAKE: begin
          bcnt = bcnt + 16'd1;
          if (bcnt < {8'd0, wake_cnt}) emit(8'hFF, 1'b0, 1'b1, 1'b0);
          else cmd_begin(sdh_pkg::P_CMD0, sdh_pkg::C_CMD0, 32'd0);
        end
        sdh_pkg::P_GAP0: cmd_begin(sdh_pkg::P_CMD8, sdh_pkg::C_CMD8, 32'h1AA);
        sdh_pkg::P_OCR8, sdh_pkg::P_OCR58: begin
          ocr[bcnt[1:0]] = m;
          bcnt = bcnt + 16'd1;
          if (bcnt < 16'd4) emit(8'hFF, 1'b1, 1'b0, 1'b0);
          else if (phase == sdh_pkg::P_OCR58) begin
            ctype = ocr[0][6] ? sdh_pkg::CT_SDV2_BL : sdh_pkg::CT_SDV2_BY;
            end_request(sdh_pkg::ST_OK);
          end else if (ocr[2] == 8'h01 && ocr[3] == 8'hAA) begin
            tries_left = tries_v2;
            if (tries_left == 15'd0) end_request(sdh_pkg::ST_OK);
            else cmd_begin(sdh_pkg::P_V2LOOP, sdh_pkg::C_ACMD41, 32'h4000_0000);
          end else end_request(sdh_pkg::ST_OK);
        end
        sdh_pkg::P_RDGAP: begin
          phase = sdh_pkg::P_RDTOK;
          bcnt  = '0;
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end
        sdh_pkg::P_RDTOK: begin
          got = poll_for(m, 8'hFE);
          if (got > 0) begin
            phase = sdh_pkg::P_RDDATA;
            bcnt  = '0;
            emit(8'hFF, 1'b1, 1'b0, 1'b0);
          end else if (got < 0) end_request(sdh_pkg::ST_RD_FAIL);
        end
        sdh_pkg::P_RDDATA: begin
          nxt.data_valid = 1'b1;
          nxt.data_byte  = m;
          bcnt = bcnt + 16'd1;
          if (bcnt >= 16'(sdh_pkg::BLOCK_BYTES)) begin
            phase = sdh_pkg::P_RDCRC;
            bcnt  = '0;
          end
          emit(8'hFF, 1'b1, 1'b0, 1'b0);
        end
        sdh_pkg::P_RDCRC, sdh_pkg::P_WRCRC: begin
          bcnt = bcnt + 16'd1;
          if (bcnt < 16'd2) emit(8'hFF, 1'b1, 1'b0, 1'b0);
          else if (phase == sdh_pkg::P_RDCRC) end_request(sdh_pkg::ST_OK);
          else begin
            phase = sdh_pkg::P_WRRESP;
            emit(8'hFF, 1'b1, 1'b0, 1'b0);
          end
        end
        sdh_pkg::P_WRGAP: begin
          phase = sdh_pkg::P_WRTOK;
          emit(8'hFE, 1'b1, 1'b0, 1'b1);
        end
        sdh_pkg::P_WRTOK: begin
          phase = sdh_pkg::P_WRDATA;
          bcnt  = '0;
          emit(wb, 1'b1, 1'b0, sdh_pkg::BLOCK_BYTES > 1);
        end
        sdh_pkg::P_WRDATA: begin
          if (int'(bcnt) + 1 < sdh_pkg::BLOCK_BYTES) begin
            bcnt = bcnt + 16'd1;
            emit(wb, 1'b1, 1'b0, int'(bcnt) + 1 < sdh_pkg::BLOCK_BYTES);
          end else begin
            phase = sdh_pkg::P_WRCRC;
            bcnt  = '0;
            emit(8'hFF, 1'b1, 1'b0, 1'b0);
          end
        end
        sdh_pkg::P_WRRESP: begin
          if (m[4:0] != 5'h05) end_request(sdh_pkg::ST_WR_FAIL);
          else begin
            phase = sdh_pkg::P_WRBUSY;
            bcnt  = '0;
            emit(8'hFF, 1'b1, 1'b0, 1'b0);
          end
        end
        sdh_pkg::P_WRBUSY: begin
          got = poll_for(m, 8'hFF);
          if (got > 0) end_request(sdh_pkg::ST_OK);
          else if (got < 0) end_request(sdh_pkg::ST_WR_FAIL);
        end
        default: phase = sdh_pkg::P_IDLE;
      endcase
    end
    nxt.card_type = ctype;
    return nxt;
  endfunction

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fails++;
    end
  endtask

  // Compare one result word against the oldest prediction.
  task automatic check_word(logic [31:0] d);
    sdh_pkg::res_t e;
    if (expected_words.size() == 0) begin
      $error("result word 0x%07h arrived with none expected", d[26:0]);
      fails++;
      return;
    end
    e = expected_words.pop_front();
    check_field("send_valid", int'(e.send_valid), int'(d[0]));
    check_field("mosi_byte", int'(e.mosi_byte), int'(d[8:1]));
    check_field("chip_select", int'(e.chip_select), int'(d[9]));
    check_field("slow_clock", int'(e.slow_clock), int'(d[10]));
    check_field("wants_write_byte", int'(e.wants_write_byte), int'(d[11]));
    check_field("data_valid", int'(e.data_valid), int'(d[12]));
    check_field("data_byte", int'(e.data_byte), int'(d[20:13]));
    check_field("done_res", int'(e.done_res), int'(d[21]));
    check_field("status", int'(e.status), int'(d[23:22]));
    check_field("card_type", int'(e.card_type), int'(d[26:24]));
    if (e.done_res) requests_done++;
  endtask

  initial begin
    fails         = 0;
    pending       = 0;
    results_seen  = 0;
    requests_done = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      resp_tries = 8'd10;
      tok_limit  = 16'd65535;
      tries_v2   = 15'd12000;
      tries_v1   = 15'd25000;
      wake_cnt   = 8'd10;
      phase      = sdh_pkg::P_IDLE;
      cmd_code   = '0;
      cmd_arg    = '0;
      app_pend   = 1'b0;
      bcnt       = '0;
      tries_left = '0;
      ctype      = sdh_pkg::CT_UNKNOWN;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sdh_pkg::R_RESP_TRIES: resp_tries = cfg_data[7:0];
          sdh_pkg::R_TOK_TMO:    tok_limit  = cfg_data[15:0];
          sdh_pkg::R_TRIES_V2:   tries_v2   = cfg_data[14:0];
          sdh_pkg::R_TRIES_V1:   tries_v1   = cfg_data[14:0];
          sdh_pkg::R_WAKE:       wake_cnt   = cfg_data[7:0];
          default: ;
        endcase
      end
      // pop before push: a result never belongs to the word taken at the same edge
      if (out_tvalid && out_tready) begin
        results_seen++;
        check_word(out_tdata);
      end
      if (in_tvalid && in_tready)
        expected_words.push_back(next_step(in_tuser, in_tdata[31:0], in_tdata[39:32],
                                           in_tdata[47:40]));
    end
    pending <= expected_words.size();
  end

endmodule

>>> bench/tb_top.sv
// Testbench top for the SD card SPI-mode host sequencer: clock, reset, stimulus
// of card-like byte exchange sequences, register phases and the verdict.
// Depends on sdh_pkg, sdh_checker and sd_spi_host_sequencer.
module tb_top;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS  = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int fails, pending, results_seen, requests_done;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int words_sent = 0;
  int wake_now  = 10;

  always #4 clk = ~clk;

  sd_spi_host_sequencer uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sdh_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fails, .pending, .results_seen, .requests_done
  );

  // receiver stalls
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Send one word, with a random idle stretch in front of it.
  task automatic put(logic [1:0] k, logic [31:0] a, logic [7:0] m, logic [7:0] wb);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {wb, m, a};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic xchg(logic [7:0] m);
    put(sdh_pkg::K_XCHG, $urandom, m, 8'($urandom));
  endtask

  // One command frame's worth of card bytes: filler, busy polls, response.
  task automatic frame_reply(logic [7:0] r);
    repeat (8) xchg(8'($urandom));
    repeat ($urandom_range(2)) xchg(8'h80 | 8'($urandom_range(127)));
    xchg(r);
  endtask

  // Mostly the wanted response, now and then a random one.
  function automatic logic [7:0] maybe_bad(logic [7:0] r);
    return ($urandom_range(19) == 0) ? 8'($urandom) : r;
  endfunction

  task automatic cmd_reply(bit app, logic [7:0] r);
    if (app) frame_reply(maybe_bad(8'($urandom_range(1))));
    frame_reply(maybe_bad(r));
  endtask

  // Power-up sequence for a card of the given family: 0 SDv2, 1 SDv1, 2 MMC.
  task automatic card_init(int fam);
    put(sdh_pkg::K_INIT, $urandom, 8'($urandom), 8'($urandom));
    repeat (wake_now) xchg(8'($urandom));
    cmd_reply(1'b0, 8'h01);
    xchg(8'($urandom));
    if (fam == 0) begin
      cmd_reply(1'b0, 8'h01);
      xchg(8'($urandom));
      xchg(8'($urandom));
      xchg(maybe_bad(8'h01));
      xchg(maybe_bad(8'hAA));
      repeat ($urandom_range(3)) cmd_reply(1'b1, 8'h01);
      cmd_reply(1'b1, 8'h00);
      cmd_reply(1'b0, 8'h00);
      repeat (4) xchg(8'($urandom));
    end else begin
      cmd_reply(1'b0, 8'h05);
      if (fam == 1) cmd_reply(1'b1, 8'h01);
      else frame_reply(8'h05);
      repeat ($urandom_range(3)) cmd_reply(fam == 1, 8'h01);
      cmd_reply(fam == 1, 8'h00);
      cmd_reply(1'b0, 8'h00);
    end
  endtask

  task automatic block_read();
    put(sdh_pkg::K_READ, $urandom, 8'($urandom), 8'($urandom));
    cmd_reply(1'b0, 8'h00);
    xchg(8'($urandom));
    repeat ($urandom_range(4)) xchg(8'hFF);
    xchg(maybe_bad(8'hFE));
    repeat (sdh_pkg::BLOCK_BYTES + 2) xchg(8'($urandom));
  endtask

  task automatic block_write();
    put(sdh_pkg::K_WRITE, $urandom, 8'($urandom), 8'($urandom));
    cmd_reply(1'b0, 8'h00);
    repeat (sdh_pkg::BLOCK_BYTES + 4) xchg(8'($urandom));
    xchg(maybe_bad({3'($urandom), 5'h05}));
    repeat ($urandom_range(4)) xchg(8'h00);
    xchg(8'hFF);
  endtask

  // Wait until every result is in and the block has settled.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int unsigned v);
    int unsigned w;
    w = (idx == sdh_pkg::R_TOK_TMO) ? 16 :
        (idx == sdh_pkg::R_TRIES_V2 || idx == sdh_pkg::R_TRIES_V1) ? 15 : 8;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (($urandom >> w) << w) | v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if (idx == sdh_pkg::R_WAKE) wake_now = int'(v);
  endtask

  task automatic set_regs(int unsigned rt, int unsigned tt, int unsigned t2,
                          int unsigned t1, int unsigned wk);
    drain();
    reg_write(sdh_pkg::R_RESP_TRIES, rt);
    reg_write(sdh_pkg::R_TOK_TMO, tt);
    reg_write(sdh_pkg::R_TRIES_V2, t2);
    reg_write(sdh_pkg::R_TRIES_V1, t1);
    reg_write(sdh_pkg::R_WAKE, wk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sel;
    int start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle exchanges, extreme addresses, request while busy
    xchg(8'h00);
    xchg(8'hFF);
    put(sdh_pkg::K_READ, 32'h0000_0000, 8'h00, 8'h00);
    xchg(8'hFF);
    xchg(8'h00);
    put(sdh_pkg::K_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    repeat (3) xchg(8'hFF);
    put(sdh_pkg::K_INIT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    repeat (4) xchg(8'h00);
    put(sdh_pkg::K_READ, 32'hA5A5_5A5A, 8'h5A, 8'hA5);
    repeat (8) xchg(8'hFF);
    xchg(8'h02);
    xchg(8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(10, 65535, 12000, 25000, 10);
        1: set_regs(1, 1, 1, 1, 1);
        2: set_regs(255, 65535, 32767, 32767, 255);
        default: set_regs($urandom_range(12), $urandom_range(8), $urandom_range(3),
                          $urandom_range(3), $urandom_range(4));
      endcase
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      start = words_sent;
      while (words_sent - start < PHASE_ITEMS) begin
        sel = int'($urandom_range(99));
        if (sel < 35) card_init(int'($urandom_range(2)));
        else if (sel < 48) block_read();
        else if (sel < 61) block_write();
        else repeat ($urandom_range(1, 5))
          put(2'($urandom_range(3)), $urandom, 8'($urandom), 8'($urandom));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d words over four register and idling phases, checked %0d results,",
             words_sent, results_seen);
    $display("%0d requests ran to completion (init, block read, block write).",
             requests_done);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
